FILE: rtl/core/bpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types, codes and helpers of the bracket pair matcher.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  // Operation codes
  localparam logic OP_BRACKET = 1'b0;
  localparam logic OP_EOL     = 1'b1;

  // Result kinds
  localparam logic RESULT_MARK = 1'b0;
  localparam logic RESULT_LINE = 1'b1;

  // Bracket kind with no meaning
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Mark for a bracket without partner
  localparam logic [1:0] MARK_UNPAIRED = 2'd3;

  // Remainder by three: base-4 digits sum modulo three, since 4 = 1 mod 3
  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 3; i >= 0; i--) begin
      r = r + {1'b0, v[2*i +: 2]};
      if (r >= 3'd3) begin
        r = r - 3'd3;
      end
    end
    return r[1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bracket_pair_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_pair_matcher
// Stack of open brackets that colours bracket pairs by depth and packs the
// carried-over brackets into a line state word at each end of line.
// ----------------------------------------------------------------------------
// Usage: drive a word on the input ports and raise start; it is taken at the
// edge where start is high and busy is low. Results come out one per cycle on
// the result ports while strobe is high; last marks the final result of the
// word. The receiver cannot stall, so no result is ever held back.
// Timing: an opener, an unmatched closer and an end of line give their single
// result in the cycle after the word is taken, with busy staying low, so such
// words go in every cycle. A masked bracket word or one of kind 3 gives nothing.
// A matched closer at stack index m with count entries searches the kind
// lanes in the accept cycle, then reads the column memory once for each entry
// from m+1 up to count-1 and for m (one read a cycle); busy stays high
// through the drain and finish states. The column memory port sets that pace.
// Reset empties the stack; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bracket_pair_matcher #(
  parameter int STACK_DEPTH = 16,
  parameter int CARRIED_MAX = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic [1:0]  bracket_kind,
  input  wire logic        is_close,
  input  wire logic        masked,
  input  wire logic [15:0] column,
  input  wire logic [2:0]  comment_bits,
  output logic             strobe,
  output logic             result_kind,
  output logic [15:0]      mark_column,
  output logic [1:0]       mark,
  output logic [31:0]      line_state,
  output logic             last
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Control state
  bpm_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] addr, addr_next;
  logic          pend, pend_next;
  logic [1:0]    pend_mark, pend_mark_next;

  // Per-entry lanes and column memory
  logic [1:0]             kind_lane [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] on_line;
  logic [15:0]            col_mem [STACK_DEPTH];
  logic [15:0]            rd_col;

  // Closer context held during the scan
  logic [AW-1:0] match_idx;
  logic [1:0]    match_color;
  logic [15:0]   close_col;

  // Decode of the word at the ports
  logic          accept;
  logic          do_eol, do_push, do_full, do_close;
  logic          hit_found;
  logic [AW-1:0] hit_idx;
  logic [CW-1:0] hit_ext, hit_inc;
  logic [CW-1:0] keep;
  logic [7:0]    keep8;
  logic [31:0]   packed_state;
  logic [AW-1:0] push_idx;

  // Output register next values
  logic          out_load;
  logic          out_kind_next;
  logic [15:0]   out_col_next;
  logic [1:0]    out_mark_next;
  logic [31:0]   out_state_next;
  logic          out_last_next;

  assign busy     = (state != bpm_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign push_idx = count[AW-1:0];

  // Classify the incoming word
  always_comb begin
    do_eol   = accept && (operation == bpm_pkg::OP_EOL);
    do_push  = 1'b0;
    do_full  = 1'b0;
    do_close = 1'b0;
    if (accept && (operation == bpm_pkg::OP_BRACKET) && !masked &&
        (bracket_kind != bpm_pkg::KIND_NONE)) begin
      if (is_close) begin
        do_close = 1'b1;
      end else if (count == CW'(STACK_DEPTH)) begin
        do_full = 1'b1;
      end else begin
        do_push = 1'b1;
      end
    end
  end

  // Search the live lanes for the topmost opener of the closer's kind
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int j = 0; j < STACK_DEPTH; j++) begin
      if ((CW'(j) < count) && (kind_lane[j] == bracket_kind)) begin
        hit_found = 1'b1;
        hit_idx   = AW'(j);
      end
    end
    hit_ext = CW'(hit_idx);
    hit_inc = hit_ext + CW'(1);
  end

  // Pack the carried entries for end of line
  always_comb begin
    keep  = (count < CW'(CARRIED_MAX)) ? count : CW'(CARRIED_MAX);
    keep8 = 8'(keep);
    packed_state      = '0;
    packed_state[2:0] = comment_bits;
    packed_state[7:3] = keep8[4:0];
    for (int i = 0; i < CARRIED_MAX; i++) begin
      if (CW'(i) < keep) begin
        packed_state[8 + 2*i +: 2] = kind_lane[i];
      end
    end
  end

  // Next state, scan sequencing and result selection
  always_comb begin
    state_next     = state;
    count_next     = count;
    addr_next      = addr;
    pend_next      = 1'b0;
    pend_mark_next = bpm_pkg::MARK_UNPAIRED;
    out_load       = 1'b0;
    out_kind_next  = bpm_pkg::RESULT_MARK;
    out_col_next   = '0;
    out_mark_next  = '0;
    out_state_next = '0;
    out_last_next  = 1'b0;

    // Emit a skipped or opener mark read in the previous cycle
    if (pend) begin
      out_load      = 1'b1;
      out_col_next  = rd_col;
      out_mark_next = pend_mark;
    end

    unique case (state)
      bpm_pkg::S_IDLE: begin
        if (do_eol) begin
          count_next     = keep;
          out_load       = 1'b1;
          out_kind_next  = bpm_pkg::RESULT_LINE;
          out_state_next = packed_state;
          out_last_next  = 1'b1;
        end else if (do_push) begin
          count_next    = count + CW'(1);
          out_load      = 1'b1;
          out_col_next  = column;
          out_mark_next = bpm_pkg::mod3(8'(count));
          out_last_next = 1'b1;
        end else if (do_full || (do_close && !hit_found)) begin
          out_load      = 1'b1;
          out_col_next  = column;
          out_mark_next = bpm_pkg::MARK_UNPAIRED;
          out_last_next = 1'b1;
        end else if (do_close) begin
          state_next = bpm_pkg::S_SCAN;
          addr_next  = (hit_inc < count) ? hit_inc[AW-1:0] : hit_idx;
        end
      end
      bpm_pkg::S_SCAN: begin
        // Issue one column read; the opener itself is read last
        pend_next      = on_line[addr];
        pend_mark_next = (addr == match_idx) ? match_color : bpm_pkg::MARK_UNPAIRED;
        if (addr == match_idx) begin
          state_next = bpm_pkg::S_DRAIN;
        end else if ((CW'(addr) + CW'(1)) == count) begin
          addr_next = match_idx;
        end else begin
          addr_next = addr + AW'(1);
        end
      end
      bpm_pkg::S_DRAIN: begin
        state_next = bpm_pkg::S_FIN;
      end
      bpm_pkg::S_FIN: begin
        // Cut the stack and emit the closer
        count_next    = CW'(match_idx);
        out_load      = 1'b1;
        out_col_next  = close_col;
        out_mark_next = match_color;
        out_last_next = 1'b1;
        state_next    = bpm_pkg::S_IDLE;
      end
      default: begin
        state_next = bpm_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bpm_pkg::S_IDLE;
      count  <= '0;
      pend   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      pend   <= pend_next;
      strobe <= out_load;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr      <= addr_next;
    pend_mark <= pend_mark_next;
    if (do_close) begin
      match_idx   <= hit_idx;
      match_color <= bpm_pkg::mod3(8'(hit_idx));
      close_col   <= column;
    end
    if (out_load) begin
      result_kind <= out_kind_next;
      mark_column <= out_col_next;
      mark        <= out_mark_next;
      line_state  <= out_state_next;
      last        <= out_last_next;
    end
  end

  // Kind lanes and on-line flags: push writes the top, end of line clears every on-line flag
  always_ff @(posedge clk) begin
    if (do_push) begin
      kind_lane[push_idx] <= bracket_kind;
      on_line[push_idx]   <= 1'b1;
    end
    if (do_eol) begin
      on_line <= '0;
    end
  end

  // Column memory: write on push, registered read during the scan
  always_ff @(posedge clk) begin
    if (do_push) begin
      col_mem[push_idx] <= column;
    end
    if (state == bpm_pkg::S_SCAN) begin
      rd_col <= col_mem[addr];
    end
  end

endmodule
`default_nettype wire
